>>> sv/pee_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and token decoding for the postfix expression evaluator
// no dependencies; imported by pee_div, pee_dp, pee_ctrl and the top level

package pee_pkg;

  // value width of the operand stack and of the reported top value
  localparam int VALUE_WIDTH     = 16;
  // default stack depth handed down from the top level
  localparam int DEF_STACK_DEPTH = 32;
  // width of the reported stack depth field
  localparam int DEPTH_W         = 6;

  // characters of interest
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_UNDER,
    ST_DIVZ,
    ST_FULL,
    ST_BADCH
  } status_t;

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_ADD,
    TK_SUB,
    TK_MUL,
    TK_DIV,
    TK_BLANK,
    TK_BAD
  } tok_t;

  // one input transaction
  typedef struct packed {
    logic [7:0] token_char;
    logic       end_of_expr;
  } in_t;

  // one result transaction
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] top_value;
    logic [DEPTH_W-1:0]            stack_depth;
    logic [2:0]                    status;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic    latch;
    logic    push;
    logic    rd_lhs;
    logic    exec;
    logic    start_div;
    logic    take_div;
    logic    wb;
    logic    report;
    status_t code;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    tok_t cls;
    logic sp_lt2;
    logic sp_full;
    logic rhs_zero;
    logic div_done;
    logic out_free;
  } stat_t;

  // classify one character
  function automatic tok_t tok_class(input logic [7:0] c);
    tok_t k;
    case (c) inside
      [CH_ZERO:CH_NINE]:        k = TK_DIGIT;
      CH_PLUS:                  k = TK_ADD;
      CH_MINUS:                 k = TK_SUB;
      CH_STAR:                  k = TK_MUL;
      CH_SLASH:                 k = TK_DIV;
      CH_SPACE, [CH_TAB:CH_CR]: k = TK_BLANK;
      default:                  k = TK_BAD;
    endcase
    return k;
  endfunction

endpackage

>>> sv/postfix_expression_evaluator.sv
`timescale 1ns / 1ps
// postfix (RPN) expression evaluator, top level
// depends on pee_pkg, pee_ctrl, pee_dp (and through it pee_ram, pee_div)
//
//   channel   direction  handshake                 payload
//   token     in         token_valid / token_stall  in_t  (token_char, end_of_expr)
//   result    out        result_valid / result_stall out_t (top_value, stack_depth, status)
//
// one result per token; one token is worked on at a time
// digit, whitespace and error tokens go through decode and report only; + - *
// add execute and write-back; / also waits on the one-bit-per-cycle divider
// reset (rst, synchronous) empties the stack; no clearing pass is needed
// a waiting result does not block the next token, which is taken at once
// and held at its report step until the result register is free

module postfix_expression_evaluator import pee_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic token_valid,
  output logic token_stall,
  input  in_t  token,
  output logic result_valid,
  input  logic result_stall,
  output out_t result
);

  cmd_t  cmd;
  stat_t stat;

  pee_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  pee_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .token        (token),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

>>> sv/pee_ram.sv
`timescale 1ns / 1ps
// generic single write, single read RAM with registered read data
// no dependencies

module pee_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/pee_div.sv
`timescale 1ns / 1ps
// signed truncating divider, restoring, one quotient bit per cycle
// depends on pee_pkg

module pee_div import pee_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  value_t dividend,
  input  value_t divisor,
  output logic   done,
  output value_t quotient
);

  localparam int CW = $clog2(VALUE_WIDTH);

  logic                 busy;
  logic                 neg;
  logic [CW-1:0]        cnt;
  value_t               rem;
  value_t               quo;
  value_t               dvs;
  value_t               a_mag;
  value_t               b_mag;
  logic [VALUE_WIDTH:0] rem_sh;
  logic [VALUE_WIDTH:0] diff;
  value_t               rem_next;
  value_t               quo_next;

  // operand magnitudes
  assign a_mag = dividend[VALUE_WIDTH-1] ? value_t'(-dividend) : dividend;
  assign b_mag = divisor[VALUE_WIDTH-1]  ? value_t'(-divisor)  : divisor;

  // one restoring step
  always_comb begin
    rem_sh = {rem, quo[VALUE_WIDTH-1]};
    diff   = rem_sh - {1'b0, dvs};
    if (diff[VALUE_WIDTH]) begin
      rem_next = rem_sh[VALUE_WIDTH-1:0];
      quo_next = {quo[VALUE_WIDTH-2:0], 1'b0};
    end else begin
      rem_next = diff[VALUE_WIDTH-1:0];
      quo_next = {quo[VALUE_WIDTH-2:0], 1'b1};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // iteration registers and sign fix on the last step
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= a_mag;
      dvs <= b_mag;
      neg <= dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
      cnt <= CW'(VALUE_WIDTH - 1);
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        quotient <= neg ? value_t'(-quo_next) : quo_next;
      end
    end
  end

endmodule

>>> sv/pee_dp.sv
`timescale 1ns / 1ps
// datapath: token register, stack pointer, top-of-stack cache, operand RAM,
// ALU, divider and result register; depends on pee_pkg, pee_ram, pee_div

module pee_dp import pee_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  in_t   token,
  input  cmd_t  cmd,
  output stat_t stat,
  output out_t  result,
  output logic  result_valid,
  input  logic  result_stall
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);

  logic [7:0]             tok;
  logic                   last;
  logic [SPW-1:0]         sp;
  logic [SPW-1:0]         sp_m2;
  value_t                 top;
  value_t                 res;
  value_t                 lhs;
  value_t                 digit;
  value_t                 div_q;
  logic                   div_done;
  logic [2*VALUE_WIDTH-1:0] prod;
  tok_t                   cls;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  value_t                 ram_wdata;

  assign cls   = tok_class(tok);
  assign sp_m2 = sp - SPW'(2);
  assign digit = VALUE_WIDTH'(tok[3:0]);
  assign prod  = lhs * top;

  // status towards the controller
  assign stat.cls      = cls;
  assign stat.sp_lt2   = sp < SPW'(2);
  assign stat.sp_full  = sp >= SPW'(STACK_DEPTH);
  assign stat.rhs_zero = top == '0;
  assign stat.div_done = div_done;
  assign stat.out_free = !result_valid || !result_stall;

  // operand stack memory, all entries; the top entry is also kept in top
  assign ram_we    = cmd.push || cmd.wb;
  assign ram_waddr = cmd.push ? sp[AW-1:0] : sp_m2[AW-1:0];
  assign ram_wdata = cmd.push ? digit : res;

  pee_ram #(
    .W     (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_lhs),
    .raddr (sp_m2[AW-1:0]),
    .rdata (lhs)
  );

  pee_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (lhs),
    .divisor  (top),
    .done     (div_done),
    .quotient (div_q)
  );

  // stack pointer and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sp           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        sp <= sp + 1'b1;
      end else if (cmd.wb) begin
        sp <= sp - 1'b1;
      end else if (cmd.report && last) begin
        sp <= '0;
      end
      if (cmd.report) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      tok  <= token.token_char;
      last <= token.end_of_expr;
    end
    if (cmd.exec) begin
      case (cls)
        TK_ADD:  res <= lhs + top;
        TK_SUB:  res <= lhs - top;
        TK_MUL:  res <= prod[VALUE_WIDTH-1:0];
        default: res <= res;
      endcase
    end else if (cmd.take_div) begin
      res <= div_q;
    end
    if (cmd.push) begin
      top <= digit;
    end else if (cmd.wb) begin
      top <= res;
    end
    if (cmd.report) begin
      result.top_value   <= (sp == '0) ? '0 : $signed(top);
      result.stack_depth <= DEPTH_W'(sp);
      result.status      <= cmd.code;
    end
  end

  // checks
  a_wb_two: assert property (@(posedge clk) disable iff (rst)
    cmd.wb |-> sp >= SPW'(2))
    else $error("write-back with fewer than two entries");
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");
  a_report_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.report |=> result_valid)
    else $error("report did not raise result valid");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.sp_full)
    else $error("push on a full stack");

endmodule

>>> sv/pee_ctrl.sv
`timescale 1ns / 1ps
// controller state machine: sequences decode, operand read, execute or
// divide, write-back and report; depends on pee_pkg

module pee_ctrl import pee_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  token_valid,
  output logic  token_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WAIT,
    S_DIV,
    S_WB,
    S_REPORT
  } state_t;

  state_t  state;
  status_t code;
  logic    is_op;

  assign is_op = stat.cls inside {TK_ADD, TK_SUB, TK_MUL, TK_DIV};

  // state and status code
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (token_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_REPORT;
          if (stat.cls == TK_DIGIT) begin
            code <= stat.sp_full ? ST_FULL : ST_OK;
          end else if (is_op) begin
            if (stat.sp_lt2) begin
              code <= ST_UNDER;
            end else if (stat.cls == TK_DIV && stat.rhs_zero) begin
              code <= ST_DIVZ;
            end else begin
              code  <= ST_OK;
              state <= S_WAIT;
            end
          end else if (stat.cls == TK_BLANK) begin
            code <= ST_OK;
          end else begin
            code <= ST_BADCH;
          end
        end
        S_WAIT: begin
          state <= (stat.cls == TK_DIV) ? S_DIV : S_WB;
        end
        S_DIV: begin
          if (stat.div_done) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          state <= S_REPORT;
        end
        S_REPORT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign token_stall = state != S_IDLE;

  // commands to the datapath
  always_comb begin
    cmd.latch     = state == S_IDLE && token_valid;
    cmd.push      = state == S_DECODE && stat.cls == TK_DIGIT && !stat.sp_full;
    cmd.rd_lhs    = state == S_DECODE && is_op && !stat.sp_lt2;
    cmd.exec      = state == S_WAIT && stat.cls != TK_DIV;
    cmd.start_div = state == S_WAIT && stat.cls == TK_DIV;
    cmd.take_div  = state == S_DIV && stat.div_done;
    cmd.wb        = state == S_WB;
    cmd.report    = state == S_REPORT && stat.out_free;
    cmd.code      = code;
  end

endmodule
